// File: src/vcf_genotype_base_extractor_top_macros.svh
// ----------------------------------------------------------------------------
// VCF genotype base extractor assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VCF_GENOTYPE_BASE_EXTRACTOR_TOP_MACROS_SVH
`define VCF_GENOTYPE_BASE_EXTRACTOR_TOP_MACROS_SVH

`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define VGB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Antecedent implies consequent in the following cycle.
`define VGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VGB_ASSERT_SAME(lbl, ante, cons, msg)
`define VGB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/vcfgbe_pkg.sv
// ----------------------------------------------------------------------------
// VCF genotype base extractor package
// Sizes, field phase codes and character constants of the record parser.
// ----------------------------------------------------------------------------
package vcfgbe_pkg;

	localparam int MAX_ALLELES = 16;
	localparam int MAX_SAMPLES = 65536;

	// Allele count and genotype index both reach MAX_ALLELES itself.
	localparam int ALLELE_W = $clog2(MAX_ALLELES + 1);
	localparam int IDX_W    = $clog2(MAX_ALLELES);
	localparam int GT_SUM_W = ALLELE_W + 4;
	localparam int SAMPLE_W = $clog2(MAX_SAMPLES);

	localparam int IN_W       = 8;
	localparam int POS_W      = 32;
	localparam int SAMPLE_O_W = 16;
	localparam int BASE_W     = 8;
	localparam int OUT_W      = POS_W + SAMPLE_O_W + BASE_W;

	localparam int PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_CHROM     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_POS       = 4'd1;
	localparam logic [PHASE_W-1:0] PH_ID        = 4'd2;
	localparam logic [PHASE_W-1:0] PH_REF       = 4'd3;
	localparam logic [PHASE_W-1:0] PH_REFSEP    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_ALT       = 4'd5;
	localparam logic [PHASE_W-1:0] PH_SKIP      = 4'd6;
	localparam logic [PHASE_W-1:0] PH_GT_FIRST  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_GT_DIGITS = 4'd8;
	localparam logic [PHASE_W-1:0] PH_GT_REST   = 4'd9;

	localparam logic [IN_W-1:0] CH_TAB   = 8'h09;
	localparam logic [IN_W-1:0] CH_LF    = 8'h0A;
	localparam logic [IN_W-1:0] CH_NUL   = 8'h00;
	localparam logic [IN_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [IN_W-1:0] CH_N     = 8'h4E;
	localparam logic [IN_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [IN_W-1:0] CH_NINE  = 8'h39;

	localparam logic [1:0] SKIP_LAST = 2'd3;

endpackage

// File: src/vcf_genotype_base_extractor_top.sv
// The block parses VCF record text arriving one byte per request and emits
// one request per sample field carrying the zero-based position, the sample
// number, the allele base picked by the genotype index and a last-sample
// flag. It takes one byte every cycle; a byte is registered at the input,
// then the record state and the result register are updated from it once
// the output is free to advance. Only a stalled output with a full input
// register holds off new bytes. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
// VCF genotype base extractor
// Byte-serial record parser: position, allele table and per-sample genotype.
// ----------------------------------------------------------------------------
`include "vcf_genotype_base_extractor_top_macros.svh"

module vcf_genotype_base_extractor_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// [7:0] in_byte
	input  logic [vcfgbe_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// [31:0] position, [47:32] sample_number, [55:48] base
	output logic [vcfgbe_pkg::OUT_W-1:0] m_axis_tdata,
	// last_sample
	output logic                      m_axis_tlast
);
	import vcfgbe_pkg::*;

	localparam logic [ALLELE_W-1:0] ALLELE_MAX = ALLELE_W'(MAX_ALLELES);
	localparam logic [GT_SUM_W-1:0] GT_LIMIT   = GT_SUM_W'(MAX_ALLELES);
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(MAX_SAMPLES - 1);

	// Input register.
	logic            valid_s1;
	logic [IN_W-1:0] byte_s1;

	// Record state.
	logic [PHASE_W-1:0]  phase_q, phase_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [ALLELE_W-1:0] count_q, count_d;
	logic [1:0]          skip_q, skip_d;
	logic [ALLELE_W-1:0] gt_q, gt_d;
	logic                inv_q, inv_d;
	logic [SAMPLE_W-1:0] sample_q, sample_d;
	logic [BASE_W-1:0]   allele_q [MAX_ALLELES];

	// Result register.
	logic                  out_valid_q;
	logic [POS_W-1:0]      out_pos_q;
	logic [SAMPLE_O_W-1:0] out_sample_q;
	logic [BASE_W-1:0]     out_base_q;
	logic                  out_last_q;

	logic                advance;
	logic                step;
	logic                is_tab;
	logic                ends;
	logic                is_digit;
	logic [3:0]          digit;
	logic [GT_SUM_W-1:0] gt_sum;
	logic [ALLELE_W-1:0] gt_next;
	logic                store;
	logic                emit;
	logic                emit_inv;
	logic [BASE_W-1:0]   base_sel;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign step          = valid_s1 && advance;

	assign is_tab   = (byte_s1 == CH_TAB);
	assign ends     = is_tab || (byte_s1 == CH_LF) || (byte_s1 == CH_NUL);
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign digit    = byte_s1[3:0];

	// Genotype accumulation saturates at MAX_ALLELES, which is out of range.
	assign gt_sum  = (GT_SUM_W'(gt_q) << 3) + (GT_SUM_W'(gt_q) << 1) + GT_SUM_W'(digit);
	assign gt_next = ((gt_q >= ALLELE_MAX) || (gt_sum > GT_LIMIT)) ? ALLELE_MAX
		: gt_sum[ALLELE_W-1:0];

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		count_d  = count_q;
		skip_d   = skip_q;
		gt_d     = gt_q;
		inv_d    = inv_q;
		sample_d = sample_q;
		store    = 1'b0;
		emit     = 1'b0;
		emit_inv = inv_q;
		case (phase_q)
			PH_CHROM: begin
				if (is_tab) phase_d = PH_POS;
			end
			PH_POS: begin
				if (is_tab) begin
					phase_d = PH_ID;
				end else begin
					pos_d = (pos_q << 3) + (pos_q << 1) + POS_W'(byte_s1) - POS_W'(CH_ZERO);
				end
			end
			PH_ID: begin
				if (is_tab) phase_d = PH_REF;
			end
			PH_REF: begin
				store   = 1'b1;
				phase_d = PH_REFSEP;
			end
			PH_REFSEP: begin
				phase_d = PH_ALT;
			end
			PH_ALT: begin
				if (is_tab) begin
					skip_d  = '0;
					phase_d = PH_SKIP;
				end else if (byte_s1 != CH_COMMA) begin
					store = 1'b1;
				end
			end
			PH_SKIP: begin
				if (is_tab) begin
					if (skip_q == SKIP_LAST) begin
						skip_d  = '0;
						gt_d    = '0;
						inv_d   = 1'b0;
						phase_d = PH_GT_FIRST;
					end else begin
						skip_d = skip_q + 2'd1;
					end
				end
			end
			PH_GT_FIRST: begin
				if (ends) begin
					emit     = 1'b1;
					emit_inv = 1'b1;
				end else if (is_digit) begin
					gt_d    = (GT_SUM_W'(digit) > GT_LIMIT) ? ALLELE_MAX : ALLELE_W'(digit);
					phase_d = PH_GT_DIGITS;
				end else begin
					inv_d   = 1'b1;
					phase_d = PH_GT_REST;
				end
			end
			PH_GT_DIGITS: begin
				if (ends) begin
					emit = 1'b1;
				end else if (is_digit) begin
					gt_d = gt_next;
				end else begin
					phase_d = PH_GT_REST;
				end
			end
			PH_GT_REST: begin
				if (ends) emit = 1'b1;
			end
			default: begin
				phase_d  = PH_CHROM;
				pos_d    = '0;
				count_d  = '0;
				skip_d   = '0;
				gt_d     = '0;
				inv_d    = 1'b0;
				sample_d = '0;
			end
		endcase

		if (store && (count_q < ALLELE_MAX)) count_d = count_q + ALLELE_W'(1);

		if (emit) begin
			if (!is_tab) begin
				// A newline or zero byte closes the record.
				phase_d  = PH_CHROM;
				pos_d    = '0;
				count_d  = '0;
				skip_d   = '0;
				sample_d = '0;
			end else begin
				phase_d = PH_GT_FIRST;
				if (sample_q < SAMPLE_MAX) sample_d = sample_q + SAMPLE_W'(1);
			end
			gt_d  = '0;
			inv_d = 1'b0;
		end
	end

	// An index below the count always fits the table index width.
	assign base_sel = (!emit_inv && (gt_q < count_q)) ? allele_q[gt_q[IDX_W-1:0]] : CH_N;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) byte_s1 <= s_axis_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CHROM;
			pos_q    <= '0;
			count_q  <= '0;
			skip_q   <= '0;
			gt_q     <= '0;
			inv_q    <= 1'b0;
			sample_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			count_q  <= count_d;
			skip_q   <= skip_d;
			gt_q     <= gt_d;
			inv_q    <= inv_d;
			sample_q <= sample_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && store && (count_q < ALLELE_MAX)) begin
			allele_q[count_q[IDX_W-1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_pos_q    <= pos_q - POS_W'(1);
			out_sample_q <= SAMPLE_O_W'(sample_q);
			out_base_q   <= base_sel;
			out_last_q   <= !is_tab;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_base_q, out_sample_q, out_pos_q};
	assign m_axis_tlast  = out_last_q;

	`VGB_ASSERT_NEXT(a_record_clear, step && emit && !is_tab, (phase_q == PH_CHROM) && (count_q == '0) && (pos_q == '0), "record state not cleared after last sample")
	`VGB_ASSERT_SAME(a_gt_range, 1'b1, gt_q <= ALLELE_MAX, "genotype index above saturation value")
	`VGB_ASSERT_SAME(a_count_range, 1'b1, count_q <= ALLELE_MAX, "allele count above table size")
	`VGB_ASSERT_SAME(a_stall_cause, !s_axis_tready, valid_s1 && out_valid_q && !m_axis_tready, "input stalled without output back-pressure")
	`VGB_ASSERT_NEXT(a_emit_valid, step && emit, m_axis_tvalid, "sample end did not produce a result")

endmodule
